/* rtl/phrs_pkg.sv */
// Package for the partition halo row scan: field widths, codes and shared types.
`default_nettype none
package phrs_pkg;

  // Widths of the request and result fields.
  localparam int MODE_W  = 2;
  localparam int PART_W  = 4;
  localparam int IDX_W   = 20;
  localparam int ROW_W   = 12;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 13;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_BLOCK  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] PART_COUNT_RESET = 5'd1;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONZERO = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

  // The halo counter saturates here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  // Write of one partition range into the range table.
  typedef struct packed {
    logic              en;
    logic [PART_W-1:0] idx;
    logic [IDX_W-1:0]  low;
    logic [IDX_W-1:0]  high;
  } range_wr_t;

endpackage
`default_nettype wire

/* rtl/partition_halo_row_scan.sv */
// Top level of the partition halo row scan: row bitmap memory, control and streams.
`default_nettype none
//
//  Channel  Direction  Contents
//  -------  ---------  ------------------------------------------------------------
//  in_      slave      one request: mode in tuser, range or row/column in tdata
//  out_     master     one result per request: row mask, halo flag, halo count
//  cfg_     write      part_count (index 0) and own_block (index 1)
//
//  For every request the accept edge reads the bitmap row from the
//  synchronous memory and registers the range hits; once the result register is
//  free, the busy state writes the updated row back (nonzero requests only) and loads the result register.
//  After reset, and after every clear request, a clearing pass writes zero to one
//  bitmap row per cycle, from row 0 up to the last row; no request is taken meanwhile.
//  A result waiting on out_ holds only the write-back of the next request.
//
module partition_halo_row_scan #(
  parameter int MAX_PARTS  = 16,
  parameter int BLOCK_ROWS = 4096,
  parameter int INDEX_BITS = 20
) (
  input  wire                                clk,
  input  wire                                rst_n,

  input  wire                                in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: part_index[4], range_low[20], range_high[20],
  // row_offset[12], column[20], zero pad[4].
  input  wire [phrs_pkg::IN_DATA_W-1:0]      in_tdata,
  // Fields from bit 0: mode[2], zero pad[6].
  input  wire [phrs_pkg::IN_USER_W-1:0]      in_tuser,

  output logic                               out_tvalid,
  input  wire                                out_tready,
  // Fields from bit 0: row_mask[16], row_has_halo[1], halo_row_count[13],
  // zero pad[2].
  output logic [phrs_pkg::OUT_DATA_W-1:0]    out_tdata,

  input  wire                                cfg_we,
  input  wire [phrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [phrs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int RW = (AW > phrs_pkg::ROW_W) ? AW : phrs_pkg::ROW_W;
  localparam int MW = (MAX_PARTS > phrs_pkg::MASK_W) ? MAX_PARTS : phrs_pkg::MASK_W;
  localparam logic [AW-1:0] LAST_ROW = AW'(BLOCK_ROWS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  // Request field unpacking.
  logic [phrs_pkg::MODE_W-1:0] in_mode;
  logic [phrs_pkg::PART_W-1:0] in_part;
  logic [phrs_pkg::IDX_W-1:0]  in_low;
  logic [phrs_pkg::IDX_W-1:0]  in_high;
  logic [phrs_pkg::ROW_W-1:0]  in_row;
  logic [phrs_pkg::IDX_W-1:0]  in_col;
  logic [RW-1:0]               in_row_wide;
  logic                        in_row_ok;
  logic                        accept;

  assign in_mode     = in_tuser[1:0];
  assign in_part     = in_tdata[3:0];
  assign in_low      = in_tdata[23:4];
  assign in_high     = in_tdata[43:24];
  assign in_row      = in_tdata[55:44];
  assign in_col      = in_tdata[75:56];
  assign in_row_wide = RW'(in_row);
  assign in_row_ok   = (32'(in_row) < BLOCK_ROWS);

  logic [1:0] state_r, state_nxt;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Configuration registers.
  logic [phrs_pkg::CFG_DATA_W-1:0] part_count_r;
  logic [phrs_pkg::PART_W-1:0]     own_block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= phrs_pkg::PART_COUNT_RESET;
      own_block_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phrs_pkg::CFG_PART_COUNT: part_count_r <= cfg_wdata;
        phrs_pkg::CFG_OWN_BLOCK:  own_block_r  <= cfg_wdata[phrs_pkg::PART_W-1:0];
        default: ;
      endcase
    end
  end

  // Range table and the per-partition column test.
  phrs_pkg::range_wr_t  range_wr;
  logic [MAX_PARTS-1:0] hit;

  assign range_wr.en   = accept && (in_mode == phrs_pkg::MODE_LOAD);
  assign range_wr.idx  = in_part;
  assign range_wr.low  = in_low;
  assign range_wr.high = in_high;

  phrs_range_match #(
    .MAX_PARTS  (MAX_PARTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_match (
    .clk        (clk),
    .wr         (range_wr),
    .part_count (part_count_r),
    .column     (in_col),
    .hit        (hit)
  );

  // Request held for the write-back cycle.
  logic [phrs_pkg::MODE_W-1:0] mode_r;
  logic                        row_ok_r;
  logic [AW-1:0]               addr_r;
  logic [MAX_PARTS-1:0]        hit_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      row_ok_r <= in_row_ok;
      addr_r   <= in_row_wide[AW-1:0];
      hit_r    <= hit;
    end
  end

  // Row bitmap memory: one write port and one registered read port.
  logic [MAX_PARTS-1:0] bitmap_mem [BLOCK_ROWS];
  logic [MAX_PARTS-1:0] rd_data_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAX_PARTS-1:0] mem_wdata;
  logic [AW-1:0]        sweep_addr_r, sweep_addr_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= bitmap_mem[in_row_wide[AW-1:0]];
    end
  end

  // Halo test: any set bit other than the own partition's. An own index past
  // the table leaves every bit counted as halo.
  logic [MAX_PARTS-1:0] own_mask;
  logic [MAX_PARTS-1:0] row_after;
  logic                 halo_before;
  logic                 halo_after;

  assign own_mask    = MAX_PARTS'(1) << own_block_r;
  assign row_after   = rd_data_r | hit_r;
  assign halo_before = |(rd_data_r & ~own_mask);
  assign halo_after  = |(row_after & ~own_mask);

  // Result register and halo counter.
  logic                           out_valid_r, out_valid_nxt;
  logic [phrs_pkg::MASK_W-1:0]    out_mask_r, out_mask_nxt;
  logic                           out_halo_r, out_halo_nxt;
  logic [phrs_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [phrs_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic                           finish;
  logic [MW-1:0]                  mask_wide;

  // The write-back cycle completes once the result register is free.
  assign finish = (state_r == ST_BUSY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_mask_nxt   = out_mask_r;
    out_halo_nxt   = out_halo_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = row_after;
    mask_wide      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_halo_nxt  = 1'b0;
          out_count_nxt = count_r;
          unique case (mode_r)
            phrs_pkg::MODE_LOAD: begin
            end
            phrs_pkg::MODE_CLEAR: begin
              count_nxt      = '0;
              out_count_nxt  = '0;
              sweep_addr_nxt = '0;
              state_nxt      = ST_SWEEP;
            end
            phrs_pkg::MODE_NONZERO: begin
              if (row_ok_r) begin
                mem_we = 1'b1;
                if (!halo_before && halo_after && (count_r != phrs_pkg::COUNT_MAX)) begin
                  count_nxt = count_r + 1'b1;
                end
                mask_wide     = MW'(row_after);
                out_halo_nxt  = halo_after;
                out_count_nxt = count_nxt;
              end
            end
            phrs_pkg::MODE_QUERY: begin
              if (row_ok_r) begin
                mask_wide    = MW'(rd_data_r);
                out_halo_nxt = halo_before;
              end
            end
            default: ;
          endcase
          out_mask_nxt = mask_wide[phrs_pkg::MASK_W-1:0];
        end
      end
      ST_SWEEP: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_addr_r;
        mem_wdata      = '0;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r  <= out_mask_nxt;
    out_halo_r  <= out_halo_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_halo_r, out_mask_r};

endmodule
`default_nettype wire

/* rtl/phrs_range_match.sv */
// Partition range table with one bounds comparator for each partition.
`default_nettype none
module phrs_range_match #(
  parameter int MAX_PARTS  = 16,
  parameter int INDEX_BITS = 20
) (
  input  wire                               clk,
  input  wire phrs_pkg::range_wr_t          wr,
  input  wire [phrs_pkg::CFG_DATA_W-1:0]    part_count,
  input  wire [phrs_pkg::IDX_W-1:0]         column,
  output logic [MAX_PARTS-1:0]              hit
);

  // Bounds and columns are cut to the index width.
  localparam int CW = (INDEX_BITS < phrs_pkg::IDX_W) ? INDEX_BITS : phrs_pkg::IDX_W;

  logic [CW-1:0] low_r  [MAX_PARTS];
  logic [CW-1:0] high_r [MAX_PARTS];
  logic [CW-1:0] col_cut;

  assign col_cut = column[CW-1:0];

  // A load to an index beyond the table matches no entry and is dropped.
  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PARTS; p++) begin
      if (wr.en && (32'(wr.idx) == p)) begin
        low_r[p]  <= wr.low[CW-1:0];
        high_r[p] <= wr.high[CW-1:0];
      end
    end
  end

  // Entries at or above the part count are not in use.
  always_comb begin
    for (int p = 0; p < MAX_PARTS; p++) begin
      hit[p] = (32'(part_count) > p) && (col_cut >= low_r[p]) && (col_cut <= high_r[p]);
    end
  end

endmodule
`default_nettype wire

/* test/partition_halo_row_scan_tb.sv */
// Self-checking testbench for partition_halo_row_scan: scoreboard, stream drivers and sequence.
`timescale 1ns / 1ps

module partition_halo_row_scan_tb;

  localparam int PARTS       = 16;
  localparam int ROWS        = 4096;
  localparam int HOLD_CYCLES = 300;

  // Field and bus widths taken from the package.
  localparam int MODE_W     = phrs_pkg::MODE_W;
  localparam int PART_W     = phrs_pkg::PART_W;
  localparam int IDX_W      = phrs_pkg::IDX_W;
  localparam int ROW_W      = phrs_pkg::ROW_W;
  localparam int MASK_W     = phrs_pkg::MASK_W;
  localparam int COUNT_W    = phrs_pkg::COUNT_W;
  localparam int IN_DATA_W  = phrs_pkg::IN_DATA_W;
  localparam int IN_USER_W  = phrs_pkg::IN_USER_W;
  localparam int OUT_DATA_W = phrs_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = phrs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = phrs_pkg::CFG_DATA_W;

  // Bit positions of the request fields inside in_tdata.
  localparam int LO_AT  = PART_W;
  localparam int HI_AT  = LO_AT + IDX_W;
  localparam int ROW_AT = HI_AT + IDX_W;
  localparam int COL_AT = ROW_AT + ROW_W;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [PART_W-1:0] part;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } scan_request_t;

  typedef struct {
    logic [MASK_W-1:0]  mask;
    logic               halo;
    logic [COUNT_W-1:0] count;
  } row_result_t;

  // Predicts the row masks and the halo count, and checks every result against them.
  class halo_scoreboard;
    bit [IDX_W-1:0]      range_lo [PARTS];
    bit [IDX_W-1:0]      range_hi [PARTS];
    bit [MASK_W-1:0]     row_bits [ROWS];
    bit [COUNT_W-1:0]    halo_rows;
    bit [CFG_DATA_W-1:0] parts_in_use;
    bit [PART_W-1:0]     own_part;
    row_result_t         pending[$];
    int unsigned         mode_hits [4];
    int unsigned         checked;
    int unsigned         mismatches;

    function new();
      parts_in_use = phrs_pkg::PART_COUNT_RESET;
    endfunction

    // A row is a halo row once it reaches any partition besides its own.
    function bit is_halo(bit [MASK_W-1:0] mask);
      return (mask & ~(MASK_W'(1) << own_part)) != '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == phrs_pkg::CFG_PART_COUNT) parts_in_use = data;
      else if (idx == phrs_pkg::CFG_OWN_BLOCK) own_part = data[PART_W-1:0];
    endfunction

    function void note_request(scan_request_t req);
      row_result_t     res;
      bit [MASK_W-1:0] prior_bits;
      bit [MASK_W-1:0] next_bits;
      int              n;
      mode_hits[req.mode]++;
      res.mask = '0;
      res.halo = 1'b0;
      case (req.mode)
        phrs_pkg::MODE_LOAD: begin
          range_lo[req.part] = req.lo;
          range_hi[req.part] = req.hi;
        end
        phrs_pkg::MODE_CLEAR: begin
          foreach (row_bits[i]) row_bits[i] = '0;
          halo_rows = '0;
        end
        phrs_pkg::MODE_NONZERO: begin
          prior_bits = row_bits[req.row];
          next_bits  = prior_bits;
          // Counts above the table size act as the full table.
          n = (parts_in_use > PARTS) ? PARTS : parts_in_use;
          for (int p = 0; p < n; p++) begin
            if (req.col >= range_lo[p] && req.col <= range_hi[p]) next_bits[p] = 1'b1;
          end
          row_bits[req.row] = next_bits;
          if (!is_halo(prior_bits) && is_halo(next_bits) && halo_rows != phrs_pkg::COUNT_MAX)
            halo_rows++;
          res.mask = next_bits;
          res.halo = is_halo(next_bits);
        end
        default: begin
          res.mask = row_bits[req.row];
          res.halo = is_halo(row_bits[req.row]);
        end
      endcase
      res.count = halo_rows;
      pending = {pending, res};
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      row_result_t got;
      row_result_t want;
      got.mask  = word[MASK_W-1:0];
      got.halo  = word[MASK_W];
      got.count = word[MASK_W+1 +: COUNT_W];
      checked++;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing outstanding: mask=%h halo=%0d count=%0d",
                   $time, got.mask, got.halo, got.count);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.mask !== want.mask || got.halo !== want.halo || got.count !== want.count) begin
        if (mismatches < 10) begin
          $display("%0t: result %0d expected mask=%h halo=%0d count=%0d",
                   $time, checked, want.mask, want.halo, want.count);
          $display("%0t: result %0d got      mask=%h halo=%0d count=%0d",
                   $time, checked, got.mask, got.halo, got.count);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata  = '0;
  logic [IN_USER_W-1:0]   in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  halo_scoreboard   sb;
  bit               gaps_on       = 1'b1;
  bit               hold_off_req  = 1'b0;
  logic [ROW_W-1:0] last_row      = '0;
  int unsigned      settings_used = 1;

  partition_halo_row_scan #(
    .MAX_PARTS (PARTS),
    .BLOCK_ROWS(ROWS),
    .INDEX_BITS(IDX_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels. Every accepted request is decoded from the bus itself, so the
  // prediction never depends on what the driver meant to send.
  always @(posedge clk) begin : bus_monitor
    scan_request_t req;
    if (rst_n && in_tvalid && in_tready) begin
      req.mode = in_tuser[MODE_W-1:0];
      req.part = in_tdata[PART_W-1:0];
      req.lo   = in_tdata[LO_AT +: IDX_W];
      req.hi   = in_tdata[HI_AT +: IDX_W];
      req.row  = in_tdata[ROW_AT +: ROW_W];
      req.col  = in_tdata[COL_AT +: IDX_W];
      sb.note_request(req);
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side. It stalls at random while gaps are on, and on request it holds off
  // for a long counted stretch so that the block backs up into its input.
  initial begin : result_sink
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 27);
      end
    end
  end

  function automatic logic [PART_W-1:0] rand_part();
    return PART_W'($urandom());
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom());
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ROW_W'($urandom());
  endfunction

  // Offer one request and return at the edge that accepts it. Idle cycles go in front,
  // so in_tvalid only falls when a gap really follows.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [PART_W-1:0] part,
                           input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi,
                           input logic [ROW_W-1:0] row, input logic [IDX_W-1:0] col);
    while (gaps_on && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {{(IN_USER_W-MODE_W){1'b0}}, mode};
    in_tdata  <= {{(IN_DATA_W-COL_AT-IDX_W){1'b0}}, col, row, hi, lo, part};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every result is in and the block takes requests again;
  // after a clear this covers the clearing pass over the whole bitmap. The first edge
  // makes sure the request accepted last has been noted by the monitor.
  task automatic drain_outstanding();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Narrow ranges half the time, as real partitions are; the rest are arbitrary, which
  // includes empty ranges with the low bound above the high one.
  function automatic void pick_range(output logic [IDX_W-1:0] lo, output logic [IDX_W-1:0] hi);
    int unsigned top;
    lo = rand_idx();
    if ($urandom_range(1)) begin
      top = 32'(lo) + $urandom_range(65535);
      hi  = (top > 32'hFFFFF) ? '1 : top[IDX_W-1:0];
    end else begin
      hi = rand_idx();
    end
  endfunction

  // Random traffic. Rows come mostly from a small pool, often the same row twice in a
  // row, so read-modify-write of one bitmap row is hit back to back. Most columns fall
  // inside a loaded range so that bits really get set.
  task automatic run_random(input int count);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] col;
    logic [ROW_W-1:0] row;
    int unsigned      pick;
    int unsigned      p;
    int unsigned      span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) row = ROW_W'($urandom_range(7));
      else if (pick < 8) row = last_row;
      else row = rand_row();
      last_row = row;
      col = rand_idx();
      p   = $urandom_range(PARTS-1);
      if ($urandom_range(9) < 7 && sb.range_lo[p] <= sb.range_hi[p]) begin
        span = 32'(sb.range_hi[p]) - 32'(sb.range_lo[p]) + 1;
        col  = sb.range_lo[p] + IDX_W'($urandom() % span);
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(phrs_pkg::MODE_CLEAR, rand_part(), rand_idx(), rand_idx(), row, col);
      end else if (pick < 18) begin
        pick_range(lo, hi);
        send_item(phrs_pkg::MODE_LOAD, rand_part(), lo, hi, row, col);
      end else if (pick < 43) begin
        send_item(phrs_pkg::MODE_QUERY, rand_part(), rand_idx(), rand_idx(), row, col);
      end else begin
        send_item(phrs_pkg::MODE_NONZERO, rand_part(), rand_idx(), rand_idx(), row, col);
      end
    end
  endtask

  initial begin : stimulus
    logic [IDX_W-1:0]      lo;
    logic [IDX_W-1:0]      hi;
    logic [CFG_DATA_W-1:0] count_val;
    logic [CFG_DATA_W-1:0] own_val;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every table entry is loaded before the first nonzero, so no lookup ever
    // touches an entry that was never written. Entry 0 spans the whole index space,
    // entry 2 is empty (low above high) and entry 15 holds only the top column.
    send_item(phrs_pkg::MODE_LOAD, 4'd0, '0, '1, rand_row(), rand_idx());
    send_item(phrs_pkg::MODE_LOAD, 4'd1, '0, 20'h003FF, rand_row(), rand_idx());
    send_item(phrs_pkg::MODE_LOAD, 4'd2, 20'h80000, 20'h7FFFF, rand_row(), rand_idx());
    for (int p = 3; p < PARTS-1; p++) begin
      pick_range(lo, hi);
      send_item(phrs_pkg::MODE_LOAD, PART_W'(p), lo, hi, rand_row(), rand_idx());
    end
    send_item(phrs_pkg::MODE_LOAD, 4'd15, '1, '1, rand_row(), rand_idx());

    // Default settings: only entry 0 is in use and it is the own partition, so the
    // row gets a bit but never becomes a halo row.
    send_item(phrs_pkg::MODE_NONZERO, rand_part(), rand_idx(), rand_idx(), '0, '0);
    send_item(phrs_pkg::MODE_QUERY, rand_part(), rand_idx(), rand_idx(), '0, rand_idx());
    send_item(phrs_pkg::MODE_CLEAR, rand_part(), rand_idx(), rand_idx(), rand_row(),
              rand_idx());

    for (int ph = 0; ph < 9; ph++) begin
      drain_outstanding();
      case (ph)
        0: begin count_val = 5'd16; own_val = 5'd15; end
        1: begin count_val = 5'd0;  own_val = 5'd3;  end   // no range in use at all
        2: begin count_val = 5'd31; own_val = 5'd7;  end   // count above the table size
        3: begin count_val = 5'd5;  own_val = 5'd12; end   // own partition not in use
        4: begin count_val = 5'd1;  own_val = 5'd0;  end
        5: begin count_val = 5'd16; own_val = 5'h10; end   // upper write bit is dropped
        6: begin count_val = 5'd17; own_val = 5'd15; end
        default: begin
          count_val = CFG_DATA_W'($urandom_range(31));
          own_val   = CFG_DATA_W'($urandom_range(31));
        end
      endcase
      cfg_write(phrs_pkg::CFG_PART_COUNT, count_val);
      cfg_write(phrs_pkg::CFG_OWN_BLOCK, own_val);
      settings_used++;
      gaps_on = (ph != 2);

      if (ph == 0) begin
        // Top row and top column: entries 0 and 15 match, and entry 0 is not own,
        // so the row turns halo and the count steps once.
        send_item(phrs_pkg::MODE_NONZERO, rand_part(), rand_idx(), rand_idx(), '1, '1);
        send_item(phrs_pkg::MODE_NONZERO, rand_part(), rand_idx(), rand_idx(), '1, '0);
        // Middle column: the empty entry 2 must not match.
        send_item(phrs_pkg::MODE_NONZERO, rand_part(), rand_idx(), rand_idx(), 12'd1,
                  20'h80000);
        send_item(phrs_pkg::MODE_QUERY, rand_part(), rand_idx(), rand_idx(), '1, rand_idx());
        send_item(phrs_pkg::MODE_QUERY, rand_part(), rand_idx(), rand_idx(), 12'd1,
                  rand_idx());
        run_random(45);
      end else if (ph == 3) begin
        hold_off_req = 1'b1;
        run_random(50);
      end else if (ph == 4) begin
        run_random(25);
        drain_outstanding();
        run_random(25);
      end else begin
        run_random(50);
      end
    end

    drain_outstanding();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) sb.mismatches++;

    $display("Covered %0d requests: %0d range loads, %0d clears, %0d nonzeros, %0d queries.",
             sb.mode_hits[phrs_pkg::MODE_LOAD] + sb.mode_hits[phrs_pkg::MODE_CLEAR]
             + sb.mode_hits[phrs_pkg::MODE_NONZERO] + sb.mode_hits[phrs_pkg::MODE_QUERY],
             sb.mode_hits[phrs_pkg::MODE_LOAD], sb.mode_hits[phrs_pkg::MODE_CLEAR],
             sb.mode_hits[phrs_pkg::MODE_NONZERO], sb.mode_hits[phrs_pkg::MODE_QUERY]);
    $display("%0d results checked under %0d register settings, %0d mismatches.",
             sb.checked, settings_used, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Watchdog expired with %0d results outstanding.", sb.pending.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
